[sv/eht_pkg.sv]
// Shared types and codes for the extendible hash table.
`timescale 1ns / 1ps
`default_nettype none
package eht_pkg;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One request.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
        logic [31:0]        new_value;
    } t_req;

    // One result.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [2:0]  global_depth;
        logic [6:0]  bucket_count;
        logic [2:0]  key_local_depth;
    } t_rsp;

    // Controller states.
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DIR_RD, S_BKT_RD, S_BKT_LAT, S_SC_RD, S_SC_CMP, S_RM_WR,
        S_DBL_RD, S_DBL_WR, S_SPL_INIT, S_SPL_DEP, S_SPL_RD, S_SPL_CMP,
        S_SPL_MV1, S_SPL_MV2, S_DIRW, S_FIL_OB, S_FIL_NB, S_DONE
    } t_state;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        U_NOP, U_CLR, U_LATCH, U_DIR_RD, U_BKT_RD, U_BKT_LAT, U_SC_RD, U_SC_CMP,
        U_RM_WR, U_DBL_RD, U_DBL_WR, U_SPL_INIT, U_SPL_DEP, U_SPL_RD, U_SPL_CMP,
        U_SPL_MV1, U_SPL_MV2, U_DIRW, U_FIL_OB, U_FIL_NB, U_DONE
    } t_uop;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_uop uop;
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic op_valid;
        logic is_ins;
        logic is_rem;
        logic scan_end;
        logic key_hit;
        logic can_append;
        logic need_double;
        logic at_max;
        logic no_bucket;
        logic dir_end;
        logic spl_end;
        logic spl_hit;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[sv/eht_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module eht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/eht_ctrl.sv]
// Sequencing state machine for the extendible hash table.
`timescale 1ns / 1ps
`default_nettype none
module eht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire eht_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output eht_pkg::t_cmd      o_cmd
);
    import eht_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command.
    always_comb begin
        n_state    = r_state;
        o_cmd.uop  = U_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.uop = U_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.uop = U_LATCH;
                    n_state   = S_DIR_RD;
                end
            end
            S_DIR_RD: begin
                o_cmd.uop = U_DIR_RD;
                n_state   = S_BKT_RD;
            end
            S_BKT_RD: begin
                o_cmd.uop = U_BKT_RD;
                n_state   = S_BKT_LAT;
            end
            S_BKT_LAT: begin
                o_cmd.uop = U_BKT_LAT;
                n_state   = i_stat.op_valid ? S_SC_RD : S_DONE;
            end
            S_SC_RD: begin
                o_cmd.uop = U_SC_RD;
                priority if (!i_stat.scan_end) n_state = S_SC_CMP;
                else if (!i_stat.is_ins)        n_state = S_DONE;
                else if (i_stat.can_append)     n_state = S_DONE;
                else if (i_stat.need_double)    n_state = i_stat.at_max ? S_DONE : S_DBL_RD;
                else                            n_state = S_SPL_INIT;
            end
            S_SC_CMP: begin
                o_cmd.uop = U_SC_CMP;
                if (i_stat.key_hit) n_state = i_stat.is_rem ? S_RM_WR : S_DONE;
                else                n_state = S_SC_RD;
            end
            S_RM_WR: begin
                o_cmd.uop = U_RM_WR;
                n_state   = S_DONE;
            end
            S_DBL_RD: begin
                o_cmd.uop = U_DBL_RD;
                n_state   = i_stat.dir_end ? S_SPL_INIT : S_DBL_WR;
            end
            S_DBL_WR: begin
                o_cmd.uop = U_DBL_WR;
                n_state   = S_DBL_RD;
            end
            S_SPL_INIT: begin
                o_cmd.uop = U_SPL_INIT;
                n_state   = i_stat.no_bucket ? S_DONE : S_SPL_DEP;
            end
            S_SPL_DEP: begin
                o_cmd.uop = U_SPL_DEP;
                n_state   = S_SPL_RD;
            end
            S_SPL_RD: begin
                o_cmd.uop = U_SPL_RD;
                n_state   = i_stat.spl_end ? S_DIRW : S_SPL_CMP;
            end
            S_SPL_CMP: begin
                o_cmd.uop = U_SPL_CMP;
                n_state   = i_stat.spl_hit ? S_SPL_MV1 : S_SPL_RD;
            end
            S_SPL_MV1: begin
                o_cmd.uop = U_SPL_MV1;
                n_state   = S_SPL_MV2;
            end
            S_SPL_MV2: begin
                o_cmd.uop = U_SPL_MV2;
                n_state   = S_SPL_RD;
            end
            S_DIRW: begin
                o_cmd.uop = U_DIRW;
                if (i_stat.dir_end) n_state = S_FIL_OB;
            end
            S_FIL_OB: begin
                o_cmd.uop = U_FIL_OB;
                n_state   = S_FIL_NB;
            end
            S_FIL_NB: begin
                o_cmd.uop = U_FIL_NB;
                n_state   = S_DIR_RD;
            end
            S_DONE: begin
                o_cmd.uop = U_DONE;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[sv/eht_dp.sv]
// Datapath: directory, bucket tables, slot memories and result register.
`timescale 1ns / 1ps
`default_nettype none
module eht_dp #(
    parameter int MAX_GLOBAL_DEPTH = 6,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire eht_pkg::t_cmd  i_cmd,
    input  wire eht_pkg::t_req  i_in_data,
    input  wire logic           i_cfg_valid,
    input  wire logic [3:0]     i_cfg_data,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output eht_pkg::t_rsp       o_out_data,
    output eht_pkg::t_stat      o_stat
);
    import eht_pkg::*;

    localparam int AW        = MAX_GLOBAL_DEPTH;
    localparam int DIR_SLOTS = 1 << MAX_GLOBAL_DEPTH;
    localparam int GW        = $clog2(MAX_GLOBAL_DEPTH + 1);
    localparam int FW        = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int SW        = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SAW       = AW + SW;
    localparam int DW        = MAX_GLOBAL_DEPTH + 1;

    // Control registers.
    logic [GW-1:0] r_gd;
    logic [DW-1:0] r_used;
    logic [3:0]    r_cap;
    logic [DW-1:0] r_dir;
    logic          r_out_valid;

    // Working registers of the current request.
    logic [1:0]    r_op;
    logic [31:0]   r_key;
    logic [31:0]   r_val;
    logic [AW-1:0] r_b;
    logic [AW-1:0] r_nb;
    logic [FW-1:0] r_fill;
    logic [GW-1:0] r_ld;
    logic [FW-1:0] r_slot;
    logic [FW-1:0] r_fill_ob;
    logic [FW-1:0] r_fill_nb;
    logic [AW-1:0] r_mask;
    logic [AW-1:0] r_lo_old;
    logic [AW-1:0] r_lo_new;
    logic [31:0]   r_sk;
    logic [31:0]   r_sv;
    t_status       r_status;
    logic [31:0]   r_found;
    t_rsp          r_out;

    // Memory ports.
    logic           dir_we, dir_re;
    logic [AW-1:0]  dir_waddr, dir_raddr, dir_wdata, dir_rdata;
    logic           bk_re;
    logic [AW-1:0]  bk_raddr;
    logic           fill_we;
    logic [AW-1:0]  fill_waddr;
    logic [FW-1:0]  fill_wdata, fill_rdata;
    logic           dep_we;
    logic [AW-1:0]  dep_waddr;
    logic [GW-1:0]  dep_wdata, dep_rdata;
    logic           k_we, v_we, sl_re;
    logic [SAW-1:0] sl_waddr, sl_raddr;
    logic [31:0]    k_wdata, v_wdata, k_rdata, v_rdata;

    // Derived values.
    logic [AW-1:0] gd_mask, key_slot, ld_low, ld_bit, ld_mask;
    logic [DW-1:0] n_cnt;
    logic [FW-1:0] ucap;
    logic [GW-1:0] ld_inc;
    logic          out_free;

    eht_ram #(.WIDTH(AW), .DEPTH(DIR_SLOTS)) u_dir (
        .i_clk(i_clk), .i_we(dir_we), .i_waddr(dir_waddr), .i_wdata(dir_wdata),
        .i_re(dir_re), .i_raddr(dir_raddr), .o_rdata(dir_rdata)
    );
    eht_ram #(.WIDTH(FW), .DEPTH(DIR_SLOTS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(fill_waddr), .i_wdata(fill_wdata),
        .i_re(bk_re), .i_raddr(bk_raddr), .o_rdata(fill_rdata)
    );
    eht_ram #(.WIDTH(GW), .DEPTH(DIR_SLOTS)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_waddr), .i_wdata(dep_wdata),
        .i_re(bk_re), .i_raddr(bk_raddr), .o_rdata(dep_rdata)
    );
    eht_ram #(.WIDTH(32), .DEPTH(DIR_SLOTS << SW)) u_keys (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(sl_waddr), .i_wdata(k_wdata),
        .i_re(sl_re), .i_raddr(sl_raddr), .o_rdata(k_rdata)
    );
    eht_ram #(.WIDTH(32), .DEPTH(DIR_SLOTS << SW)) u_vals (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(sl_waddr), .i_wdata(v_wdata),
        .i_re(sl_re), .i_raddr(sl_raddr), .o_rdata(v_rdata)
    );

    // Bit masks from the global and local depths.
    always_comb begin
        for (int j = 0; j < AW; j++) begin
            gd_mask[j] = (j < int'(r_gd));
            ld_low[j]  = (j < int'(r_ld));
            ld_bit[j]  = (j == int'(r_ld));
            ld_mask[j] = (j <= int'(r_ld));
        end
    end

    assign key_slot = r_key[AW-1:0] & gd_mask;
    assign n_cnt    = DW'(1) << r_gd;
    assign ld_inc   = r_ld + 1'b1;
    assign out_free = !r_out_valid || i_out_ready;

    // Usable bucket capacity: zero counts as one, clipped to the slot count.
    always_comb begin
        if (r_cap == 4'd0) begin
            ucap = FW'(1);
        end else if (32'(r_cap) > SLOTS_PER_BUCKET) begin
            ucap = FW'(SLOTS_PER_BUCKET);
        end else begin
            ucap = FW'(r_cap);
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.clr_done    = (r_dir[AW-1:0] == {AW{1'b1}});
        o_stat.op_valid    = (r_op == OP_FIND) || (r_op == OP_INSERT) || (r_op == OP_REMOVE);
        o_stat.is_ins      = (r_op == OP_INSERT);
        o_stat.is_rem      = (r_op == OP_REMOVE);
        o_stat.scan_end    = (r_slot >= r_fill);
        o_stat.key_hit     = (k_rdata == r_key);
        o_stat.can_append  = (r_fill < ucap);
        o_stat.need_double = (r_gd == r_ld);
        o_stat.at_max      = (r_gd == GW'(MAX_GLOBAL_DEPTH));
        o_stat.no_bucket   = (r_used >= DW'(DIR_SLOTS));
        o_stat.dir_end     = (r_dir >= n_cnt);
        o_stat.spl_end     = (r_slot >= r_fill_ob);
        o_stat.spl_hit     = ((k_rdata[AW-1:0] & r_mask) == r_lo_new);
        o_stat.out_free    = out_free;
    end

    // Memory port control per micro-operation.
    always_comb begin
        dir_we     = 1'b0;
        dir_waddr  = r_dir[AW-1:0];
        dir_wdata  = '0;
        dir_re     = 1'b0;
        dir_raddr  = key_slot;
        bk_re      = 1'b0;
        bk_raddr   = dir_rdata;
        fill_we    = 1'b0;
        fill_waddr = r_b;
        fill_wdata = '0;
        dep_we     = 1'b0;
        dep_waddr  = r_b;
        dep_wdata  = ld_inc;
        k_we       = 1'b0;
        v_we       = 1'b0;
        sl_waddr   = {r_b, r_slot[SW-1:0]};
        k_wdata    = k_rdata;
        v_wdata    = v_rdata;
        sl_re      = 1'b0;
        sl_raddr   = {r_b, r_slot[SW-1:0]};
        unique case (i_cmd.uop)
            U_CLR: begin
                dir_we    = 1'b1;
                fill_we   = 1'b1;
                fill_waddr = r_dir[AW-1:0];
                dep_we    = 1'b1;
                dep_waddr = r_dir[AW-1:0];
                dep_wdata = '0;
            end
            U_DIR_RD: dir_re = 1'b1;
            U_BKT_RD: bk_re = 1'b1;
            U_SC_RD: begin
                if (!o_stat.scan_end) begin
                    sl_re = 1'b1;
                end else if (o_stat.is_ins && o_stat.can_append) begin
                    k_we       = 1'b1;
                    v_we       = 1'b1;
                    sl_waddr   = {r_b, r_fill[SW-1:0]};
                    k_wdata    = r_key;
                    v_wdata    = r_val;
                    fill_we    = 1'b1;
                    fill_wdata = r_fill + 1'b1;
                end
            end
            U_SC_CMP: begin
                if (o_stat.key_hit && o_stat.is_ins) begin
                    v_we    = 1'b1;
                    v_wdata = r_val;
                end
                if (o_stat.key_hit && o_stat.is_rem) begin
                    sl_re    = 1'b1;
                    sl_raddr = {r_b, SW'(r_fill - 1'b1)};
                end
            end
            U_RM_WR: begin
                k_we       = 1'b1;
                v_we       = 1'b1;
                fill_we    = 1'b1;
                fill_wdata = r_fill - 1'b1;
            end
            U_DBL_RD: begin
                dir_re    = !o_stat.dir_end;
                dir_raddr = r_dir[AW-1:0];
            end
            U_DBL_WR: begin
                dir_we    = 1'b1;
                dir_waddr = AW'(n_cnt + r_dir);
                dir_wdata = dir_rdata;
            end
            U_SPL_INIT: dep_we = !o_stat.no_bucket;
            U_SPL_DEP: begin
                dep_we    = 1'b1;
                dep_waddr = r_nb;
            end
            U_SPL_RD: sl_re = !o_stat.spl_end;
            U_SPL_CMP: begin
                sl_re    = o_stat.spl_hit;
                sl_raddr = {r_b, SW'(r_fill_ob - 1'b1)};
            end
            U_SPL_MV1: begin
                k_we     = 1'b1;
                v_we     = 1'b1;
                sl_waddr = {r_nb, r_fill_nb[SW-1:0]};
                k_wdata  = r_sk;
                v_wdata  = r_sv;
            end
            U_SPL_MV2: begin
                k_we = 1'b1;
                v_we = 1'b1;
            end
            U_DIRW: begin
                if (!o_stat.dir_end) begin
                    if ((r_dir[AW-1:0] & r_mask) == r_lo_old) begin
                        dir_we    = 1'b1;
                        dir_wdata = r_b;
                    end else if ((r_dir[AW-1:0] & r_mask) == r_lo_new) begin
                        dir_we    = 1'b1;
                        dir_wdata = r_nb;
                    end
                end
            end
            U_FIL_OB: begin
                fill_we    = 1'b1;
                fill_wdata = r_fill_ob;
            end
            U_FIL_NB: begin
                fill_we    = 1'b1;
                fill_waddr = r_nb;
                fill_wdata = r_fill_nb;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gd        <= '0;
            r_used      <= DW'(1);
            r_cap       <= 4'd8;
            r_dir       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cap <= i_cfg_data;
            // Result valid is set by a result load and cleared when the result is taken.
            if ((i_cmd.uop == U_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.uop)
                U_CLR:      r_dir <= r_dir + 1'b1;
                U_BKT_LAT:  r_dir <= '0;
                U_DBL_RD:   if (o_stat.dir_end) r_gd <= r_gd + 1'b1;
                U_DBL_WR:   r_dir <= r_dir + 1'b1;
                U_SPL_INIT: r_dir <= '0;
                U_DIRW:     r_dir <= r_dir + 1'b1;
                U_FIL_NB:   r_used <= r_used + 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.uop)
            U_LATCH: begin
                r_op     <= i_in_data.opcode;
                r_key    <= i_in_data.key;
                r_val    <= i_in_data.new_value;
                r_status <= ST_MISS;
                r_found  <= '0;
            end
            U_BKT_RD: r_b <= dir_rdata;
            U_BKT_LAT: begin
                r_fill <= fill_rdata;
                r_ld   <= dep_rdata;
                r_slot <= '0;
            end
            U_SC_RD: begin
                if (o_stat.scan_end && o_stat.is_ins) begin
                    if (o_stat.can_append) begin
                        r_status <= ST_OK;
                    end else if (o_stat.need_double && o_stat.at_max) begin
                        r_status <= ST_FULL;
                    end
                end
            end
            U_SC_CMP: begin
                if (o_stat.key_hit) begin
                    r_status <= ST_OK;
                    if (r_op == OP_FIND) r_found <= v_rdata;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            U_SPL_INIT: begin
                if (o_stat.no_bucket) begin
                    r_status <= ST_FULL;
                end else begin
                    r_lo_old  <= key_slot & ld_low;
                    r_lo_new  <= (key_slot & ld_low) | ld_bit;
                    r_mask    <= ld_mask;
                    r_fill_ob <= r_fill;
                    r_fill_nb <= '0;
                    r_nb      <= r_used[AW-1:0];
                    r_slot    <= '0;
                end
            end
            U_SPL_CMP: begin
                if (o_stat.spl_hit) begin
                    r_sk <= k_rdata;
                    r_sv <= v_rdata;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            U_SPL_MV2: begin
                r_fill_ob <= r_fill_ob - 1'b1;
                r_fill_nb <= r_fill_nb + 1'b1;
            end
            U_DONE: begin
                if (out_free) begin
                    r_out.status          <= r_status;
                    r_out.found_value     <= r_found;
                    r_out.global_depth    <= 3'(r_gd);
                    r_out.bucket_count    <= 7'(r_used);
                    r_out.key_local_depth <= 3'(r_ld);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

[sv/extendible_hash_table_top.sv]
// Top level of the extendible hash table: controller, datapath and checks.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in_data (t_req)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_rsp)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (bucket capacity)
//
// An accepted request reads the directory and its bucket, then scans the bucket slot
// by slot to its result; an unknown opcode skips the scan. The controller returns
// to idle before the next request is taken. A split first doubles the directory
// when needed, then examines the slots, moves entries to the new bucket and
// rewrites the directory entries, then the lookup repeats. Each table has a
// single read port. After reset a clearing pass zeroes the directory and bucket
// tables before the first request. A finished result waits in the output
// register while the next request runs.
`timescale 1ns / 1ps
`default_nettype none
module extendible_hash_table_top #(
    parameter int MAX_GLOBAL_DEPTH = 6,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire eht_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output eht_pkg::t_rsp      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [3:0]    i_cfg_data
);
    import eht_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    eht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    eht_dp #(
        .MAX_GLOBAL_DEPTH (MAX_GLOBAL_DEPTH),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_stat      (w_stat)
    );

    // A request is worked on alone: ready drops right after it is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    // A new result appears only from the result load step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.uop == U_DONE))
        else $error("result valid without a result load");

    // No request is taken during the clearing pass.
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.uop == U_CLR) |-> !o_in_ready)
        else $error("request ready during clearing pass");

    // A result never carries an unused status code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("undefined result status");

endmodule
`default_nettype wire
